/* sv/flap_damping_penalty_engine_assert.svh */
// Assertion macros for the flap damping penalty engine
`ifndef FLAP_DAMPING_PENALTY_ENGINE_ASSERT_SVH
`define FLAP_DAMPING_PENALTY_ENGINE_ASSERT_SVH
// Clocked check, idle while reset is held
`define FDPE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset
`define FDPE_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* sv/fdpe_pkg.sv */
// ----------------------------------------------------------------------------
// fdpe_pkg
// Shared types, constants and the decay table for the flap damping engine.
// ----------------------------------------------------------------------------
package fdpe_pkg;

  localparam int ENTRIES        = 32;
  localparam int HALF_LIFE_SEC  = 60;
  localparam int HOLD_SEC       = 240;
  localparam int DECAY_STEP_SEC = 5;

  localparam int IDX_W    = 5;
  localparam int ENT_W    = $clog2(ENTRIES);
  localparam int WALK_W   = ENT_W + 1;
  localparam int ROM_SIZE = (HOLD_SEC + DECAY_STEP_SEC - 1) / DECAY_STEP_SEC;
  localparam int HALF_N   = HALF_LIFE_SEC / DECAY_STEP_SEC;
  localparam int K_W      = (ROM_SIZE > 1) ? $clog2(ROM_SIZE) : 1;
  localparam int DT_LIMIT = ROM_SIZE * DECAY_STEP_SEC;
  localparam int DT_W     = $clog2(DT_LIMIT + 1);
  localparam int RS       = DT_W + $clog2(DECAY_STEP_SEC + 1) + 1;
  localparam int RECIP    = ((1 << RS) + DECAY_STEP_SEC - 1) / DECAY_STEP_SEC;
  localparam int RECIP_W  = RS + 1;

  // request kinds
  localparam logic [1:0] REQ_UP   = 2'd0;
  localparam logic [1:0] REQ_DOWN = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  // result kinds
  localparam logic [1:0] RES_VERDICT = 2'd0;
  localparam logic [1:0] RES_RELEASE = 2'd1;
  localparam logic [1:0] RES_TICK    = 2'd2;

  // stored event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_UP   = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_ENABLE   = 3'd0;
  localparam logic [2:0] CFG_REUSE    = 3'd1;
  localparam logic [2:0] CFG_SUPPRESS = 3'd2;
  localparam logic [2:0] CFG_FLAP     = 3'd3;
  localparam logic [2:0] CFG_CEILING  = 3'd4;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] entry_index;
    logic [31:0]      now_time;
  } fdpe_req_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [IDX_W-1:0] target_index;
    logic             run_now;
    logic             event_kind;
    logic             damped;
    logic [15:0]      penalty_value;
    logic             last;
  } fdpe_res_t;

  typedef struct packed {
    logic        damping_enabled;
    logic [15:0] reuse_level;
    logic [15:0] suppress_level;
    logic [15:0] flap_penalty;
    logic [15:0] penalty_ceiling;
  } fdpe_cfg_t;

  typedef logic [16:0] rom_t [ROM_SIZE];

  // Q1.16 decay factors 0.5^(k/HALF_N), worked out at elaboration
  function automatic rom_t build_rom();
    logic [127:0] p, lo, hi, mid, t;
    rom_t r;
    lo = '0;
    hi = 128'd1 << 32;
    if (HALF_N != 0) begin
      while (hi - lo > 128'd1) begin
        mid = lo + ((hi - lo) >> 1);
        p = 128'd1 << 32;
        for (int i = 0; i < HALF_N && p > (128'd1 << 31); i++) begin
          p = (p * mid) >> 32;
        end
        if (p <= (128'd1 << 31)) lo = mid;
        else hi = mid;
      end
    end
    t = 128'd1 << 32;
    for (int k = 0; k < ROM_SIZE; k++) begin
      if (k > 0) t = (t * lo) >> 32;
      r[k] = t[32:16];
    end
    return r;
  endfunction

  localparam rom_t DECAY_ROM = build_rom();

endpackage

/* sv/fdpe_front.sv */
// ----------------------------------------------------------------------------
// fdpe_front
// Accepts request beats, drops unused kinds and queues the rest.
// ----------------------------------------------------------------------------
module fdpe_front import fdpe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  fdpe_req_t in_req,
  output logic      q_valid,
  input  logic      q_ready,
  output fdpe_req_t q_req
);

  fdpe_req_t   slot [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        push, pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && (in_req.req_type != REQ_NONE);
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_req    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* sv/fdpe_back.sv */
// ----------------------------------------------------------------------------
// fdpe_back
// Entry table, decay datapath and the sequencer for events and ticks.
// ----------------------------------------------------------------------------
module fdpe_back import fdpe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  fdpe_cfg_t cfg,
  input  logic      q_valid,
  output logic      q_ready,
  input  fdpe_req_t q_req,
  output logic      out_valid,
  input  logic      out_ready,
  output fdpe_res_t out_res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_KIDX = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic        ent_valid   [ENTRIES];
  logic [15:0] ent_penalty [ENTRIES];
  logic [31:0] ent_updated [ENTRIES];
  logic        ent_damped  [ENTRIES];
  logic [1:0]  ent_pending [ENTRIES];
  logic [1:0]  ent_deliv   [ENTRIES];

  logic [2:0]        st;
  fdpe_req_t         cur;
  logic [WALK_W-1:0] walk;
  logic              is_tick, in_range, bypass;
  logic [ENT_W-1:0]  addr;

  logic              vld_r, dmp_r, big_r;
  logic [15:0]       pen_r, pen_dec;
  logic [1:0]        pend_r, dlv_r;
  logic [DT_W-1:0]   dt_r;
  logic [K_W-1:0]    k_r;

  logic [31:0]                 dt_full;
  logic [DT_W+RECIP_W-1:0]     kprod;
  logic [16:0]                 fac;
  logic [32:0]                 prod;

  logic        out_free;
  logic        out_load;

  // per-step results
  logic [15:0] base, penc;
  logic [16:0] sum;
  logic        d0, d1, d2, d3, run, down;
  logic [1:0]  code, dlv0, dlv_new;
  logic        rel, emit, free_it;

  assign is_tick  = (cur.req_type == REQ_TICK);
  assign in_range = ({1'b0, cur.entry_index} < (IDX_W+1)'(ENTRIES));
  assign bypass   = !cfg.damping_enabled || !in_range;
  assign addr     = is_tick ? walk[ENT_W-1:0] : cur.entry_index[ENT_W-1:0];
  assign q_ready  = (st == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  // a new result beat is loaded this cycle
  assign out_load = out_free && (((st == ST_UPD) && (!is_tick || emit)) || (st == ST_DONE));

  assign dt_full = (cur.now_time >= ent_updated[addr]) ?
                   (cur.now_time - ent_updated[addr]) : 32'd0;
  assign kprod   = dt_r * RECIP_W'(RECIP);
  assign fac     = big_r ? 17'd0 : DECAY_ROM[k_r];

  // decide the entry update
  always_comb begin
    down    = (cur.req_type == REQ_DOWN);
    code    = down ? EV_DOWN : EV_UP;
    base    = vld_r ? pen_dec : 16'd0;
    d0      = vld_r && dmp_r;
    dlv0    = vld_r ? dlv_r : EV_NONE;
    sum     = is_tick ? {1'b0, pen_dec}
                      : ({1'b0, base} + (down ? {1'b0, cfg.flap_penalty} : 17'd0));
    penc    = (sum > {1'b0, cfg.penalty_ceiling}) ? cfg.penalty_ceiling : sum[15:0];
    d1      = (penc < cfg.reuse_level) ? 1'b0 : d0;
    d2      = d1 || (!down && penc >= cfg.suppress_level);
    run     = !d2;
    d3      = d2 || (penc >= cfg.suppress_level);
    dlv_new = run ? code : dlv0;
    rel     = (penc < cfg.reuse_level) && dmp_r;
    emit    = rel && (pend_r != EV_NONE) && (pend_r != dlv_r);
    free_it = (penc <= (cfg.reuse_level >> 1));
  end

  always_ff @(posedge clk) begin
    if (st == ST_UPD && !is_tick && !bypass) ent_updated[addr] <= cur.now_time;
    if (st == ST_UPD && is_tick) ent_updated[addr] <= cur.now_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
      walk      <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ent_valid[i]   <= 1'b0;
        ent_penalty[i] <= 16'd0;
        ent_damped[i]  <= 1'b0;
        ent_pending[i] <= EV_NONE;
        ent_deliv[i]   <= EV_NONE;
      end
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      case (st)
        ST_IDLE: begin
          if (q_valid) begin
            cur  <= q_req;
            walk <= '0;
            st   <= ST_READ;
          end
        end
        ST_READ: begin
          if (is_tick && walk == WALK_W'(ENTRIES)) begin
            st <= ST_DONE;
          end else if (is_tick && !ent_valid[addr]) begin
            walk <= walk + 1'b1;
          end else begin
            vld_r  <= in_range && ent_valid[addr];
            dmp_r  <= in_range && ent_damped[addr];
            pen_r  <= in_range ? ent_penalty[addr] : 16'd0;
            pend_r <= ent_pending[addr];
            dlv_r  <= ent_deliv[addr];
            big_r  <= (dt_full >= 32'(DT_LIMIT));
            dt_r   <= dt_full[DT_W-1:0];
            st     <= ST_KIDX;
          end
        end
        ST_KIDX: begin
          k_r <= kprod[RS+K_W-1:RS];
          st  <= ST_MUL;
        end
        ST_MUL: begin
          pen_dec <= prod[31:16];
          st      <= ST_UPD;
        end
        ST_UPD: begin
          if (out_free || (is_tick && !emit)) begin
            if (is_tick) begin
              if (free_it) begin
                ent_valid[addr]   <= 1'b0;
                ent_penalty[addr] <= 16'd0;
                ent_damped[addr]  <= 1'b0;
                ent_pending[addr] <= EV_NONE;
                ent_deliv[addr]   <= EV_NONE;
              end else begin
                ent_penalty[addr] <= penc;
                ent_damped[addr]  <= dmp_r && !rel;
                if (emit) begin
                  ent_deliv[addr]   <= pend_r;
                  ent_pending[addr] <= EV_NONE;
                end
              end
              if (emit) begin
                out_valid <= 1'b1;
                out_res   <= '{result_kind: RES_RELEASE, target_index: IDX_W'(walk),
                               run_now: 1'b1, event_kind: pend_r[1], damped: 1'b0,
                               penalty_value: penc, last: 1'b0};
              end
              walk <= walk + 1'b1;
              st   <= ST_READ;
            end else begin
              out_valid <= 1'b1;
              if (bypass) begin
                out_res <= '{result_kind: RES_VERDICT, target_index: cur.entry_index,
                             run_now: 1'b1, event_kind: down, damped: dmp_r,
                             penalty_value: pen_r, last: 1'b1};
              end else begin
                ent_valid[addr]   <= 1'b1;
                ent_penalty[addr] <= penc;
                ent_damped[addr]  <= d3;
                ent_pending[addr] <= code;
                ent_deliv[addr]   <= dlv_new;
                out_res <= '{result_kind: RES_VERDICT, target_index: cur.entry_index,
                             run_now: run, event_kind: down, damped: d3,
                             penalty_value: penc, last: 1'b1};
              end
              st <= ST_IDLE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_res   <= '{result_kind: RES_TICK, target_index: '0, run_now: 1'b0,
                           event_kind: 1'b0, damped: 1'b0, penalty_value: 16'd0,
                           last: 1'b1};
            st        <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  assign prod = pen_r * fac;

endmodule

/* sv/flap_damping_penalty_engine.sv */
// ----------------------------------------------------------------------------
// flap_damping_penalty_engine
// Per-entry flap penalty with exponential decay, damping verdicts and release.
// ----------------------------------------------------------------------------
// channel   | direction | beat carries
// s_axis    | in        | request: kind in tuser, index and time in tdata
// m_axis    | out       | result: kind in tuser, verdict in tdata, tlast
// cfg       | in        | register index and 16-bit value
//
// An up or down event goes through accept, table read, step index, decay multiply and
// update. A tick skips free entries, takes each live one through read to update, then
// sends a done beat. The back sequencer handles one request at a time; a two-deep
// queue in front takes beats until full. Reset is synchronous and clears every entry
// at once. A stalled result beat holds the sequencer only when a new beat is due.
// ----------------------------------------------------------------------------
`include "flap_damping_penalty_engine_assert.svh"
module flap_damping_penalty_engine import fdpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // entry_index[4:0], now_time[36:5], zero fill
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // target_index[4:0], run_now[5], event_kind[6],
                                      // damped[7], penalty_value[23:8]
  output logic [1:0]  m_axis_tuser,   // result_kind[1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  fdpe_cfg_t cfg;
  fdpe_req_t in_req, q_req;
  fdpe_res_t res;
  logic      q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{damping_enabled: 1'b0, reuse_level: 16'd750, suppress_level: 16'd2000,
               flap_penalty: 16'd1000, penalty_ceiling: 16'd12000};
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE:   cfg.damping_enabled <= cfg_data[0];
        CFG_REUSE:    cfg.reuse_level     <= cfg_data;
        CFG_SUPPRESS: cfg.suppress_level  <= cfg_data;
        CFG_FLAP:     cfg.flap_penalty    <= cfg_data;
        CFG_CEILING:  cfg.penalty_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_req = '{req_type: s_axis_tuser, entry_index: s_axis_tdata[4:0],
                    now_time: s_axis_tdata[36:5]};

  fdpe_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  fdpe_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
  );

  assign m_axis_tuser = res.result_kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {res.penalty_value, res.damped, res.event_kind, res.run_now,
                         res.target_index};

  `FDPE_CHECK(tick_done_is_last,
    (m_axis_tvalid && m_axis_tuser == RES_TICK) |-> m_axis_tlast,
    "tick done beat without tlast")
  `FDPE_CHECK(release_not_last,
    (m_axis_tvalid && m_axis_tuser == RES_RELEASE) |-> (!m_axis_tlast && m_axis_tdata[5]),
    "release beat malformed")
  `FDPE_CHECK(kind_known,
    m_axis_tvalid |-> (m_axis_tuser != 2'd3),
    "unknown result kind")
  `FDPE_CHECK_ALWAYS(out_idle_after_reset,
    $past(rst) |-> !m_axis_tvalid,
    "result beat straight after reset")

endmodule
